/* src/assert_macros.svh */
// Assertion macros shared by the positional list engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/ple_pkg.sv */
// Shared types and constants of the positional list engine.
package ple_pkg;

    localparam int DEPTH_DEF       = 64;
    localparam int ENTRY_WIDTH_DEF = 32;
    localparam int KIND_W          = 3;
    localparam int POS_W           = 7;
    localparam int DATA_W          = 32;
    localparam int STATUS_W        = 2;
    localparam int COUNT_W         = 7;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT  = 3'd0,
        KIND_DELETE  = 3'd1,
        KIND_REPLACE = 3'd2,
        KIND_READ    = 3'd3,
        KIND_CLEAR   = 3'd4
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_WRITE  = 2'd3
    } t_act;

    typedef struct packed {
        t_act    act;
        logic    take;
        t_status status;
    } t_ctl;

endpackage

/* src/positional_list_engine.sv */
// Positional list engine: a chain of cells that holds an ordered list of up to DEPTH entries.
// One request is taken in every clock cycle and busy never rises. Each request gives one
// result on the o_ ports in the cycle after it is taken, marked by o_strobe for that single
// cycle; the receiver cannot stall it. The rate is set by the cell chain: each cell loads,
// shifts from a neighbor or holds directly, so inserts and deletes cost the same as reads.
// Count and empty flag show the state after the request; failed requests return entry zero.
module positional_list_engine #(
    parameter int DEPTH       = ple_pkg::DEPTH_DEF,
    parameter int ENTRY_WIDTH = ple_pkg::ENTRY_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [ple_pkg::KIND_W-1:0]   i_kind,
    input  logic [ple_pkg::POS_W-1:0]    i_position,
    input  logic [ple_pkg::DATA_W-1:0]   i_entry_in,
    output logic                         o_strobe,
    output logic [ple_pkg::DATA_W-1:0]   o_entry_out,
    output logic [ple_pkg::STATUS_W-1:0] o_status,
    output logic [ple_pkg::COUNT_W-1:0]  o_count,
    output logic                         o_is_empty
);
    import ple_pkg::*;
    `include "assert_macros.svh"

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic                   w_accept;
    t_ctl                   w_ctl;
    logic [IW-1:0]          w_index;
    logic [CW-1:0]          w_count;
    logic [ENTRY_WIDTH-1:0] w_value;
    logic [ENTRY_WIDTH-1:0] w_data [DEPTH];
    logic [ENTRY_WIDTH-1:0] w_tap  [DEPTH];
    logic [ENTRY_WIDTH-1:0] w_sel;

    logic                   r_strobe;
    logic [ENTRY_WIDTH-1:0] r_entry;
    t_status                r_status;

    assign busy     = 1'b0;
    assign w_accept = start & ~busy;
    assign w_value  = ENTRY_WIDTH'(i_entry_in);

    ple_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_kind    (i_kind),
        .i_position(i_position),
        .o_ctl     (w_ctl),
        .o_index   (w_index),
        .o_count   (w_count)
    );

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [ENTRY_WIDTH-1:0] w_prev;
        logic [ENTRY_WIDTH-1:0] w_next;

        if (g == 0) begin : g_first
            assign w_prev = '0;
        end else begin : g_mid_prev
            assign w_prev = w_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_next = w_data[g];
        end else begin : g_mid_next
            assign w_next = w_data[g+1];
        end

        ple_cell #(
            .DEPTH      (DEPTH),
            .IDX        (g),
            .ENTRY_WIDTH(ENTRY_WIDTH)
        ) u_cell (
            .i_clk  (i_clk),
            .i_act  (w_ctl.act),
            .i_index(w_index),
            .i_value(w_value),
            .i_prev (w_prev),
            .i_next (w_next),
            .o_data (w_data[g]),
            .o_tap  (w_tap[g])
        );
    end

    always_comb begin
        w_sel = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_sel = w_sel | w_tap[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry  <= w_ctl.take ? w_sel : '0;
        r_status <= w_ctl.status;
    end

    assign o_strobe    = r_strobe;
    assign o_entry_out = DATA_W'(r_entry);
    assign o_status    = r_status;
    assign o_count     = COUNT_W'(w_count);
    assign o_is_empty  = (w_count == '0);

    `ASSERT_NEXT(a_strobe_follows, w_accept, o_strobe, "result strobe missing after a request")
    `ASSERT_NEXT(a_count_holds, !w_accept, $stable(w_count), "count moved without a request")
    `ASSERT_IMPL(a_fail_zero, o_strobe && (r_status != ST_OK), r_entry == '0, "failed request returned data")
    `ASSERT_IMPL(a_full_count, o_strobe && (r_status == ST_FULL), w_count == CW'(DEPTH), "full status on a list that is not full")

endmodule

/* src/ple_cell.sv */
// One storage cell of the list chain; shifts, loads or holds its entry.
module ple_cell #(
    parameter int DEPTH       = ple_pkg::DEPTH_DEF,
    parameter int IDX         = 0,
    parameter int ENTRY_WIDTH = ple_pkg::ENTRY_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  ple_pkg::t_act            i_act,
    input  logic [$clog2(DEPTH)-1:0] i_index,
    input  logic [ENTRY_WIDTH-1:0]   i_value,
    input  logic [ENTRY_WIDTH-1:0]   i_prev,
    input  logic [ENTRY_WIDTH-1:0]   i_next,
    output logic [ENTRY_WIDTH-1:0]   o_data,
    output logic [ENTRY_WIDTH-1:0]   o_tap
);
    import ple_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic [ENTRY_WIDTH-1:0] r_data;
    logic [ENTRY_WIDTH-1:0] n_data;
    logic                   w_match;

    assign w_match = (i_index == MY_IDX);

    always_comb begin
        n_data = r_data;
        case (i_act)
            ACT_INSERT: begin
                if (w_match) begin
                    n_data = i_value;
                end else if (i_index < MY_IDX) begin
                    n_data = i_prev;
                end
            end
            ACT_DELETE: begin
                if (i_index <= MY_IDX) begin
                    n_data = i_next;
                end
            end
            ACT_WRITE: begin
                if (w_match) begin
                    n_data = i_value;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_tap  = w_match ? r_data : '0;

endmodule

/* src/ple_ctrl.sv */
// Request decoder and entry counter of the positional list engine.
module ple_ctrl #(
    parameter int DEPTH = ple_pkg::DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic [ple_pkg::KIND_W-1:0] i_kind,
    input  logic [ple_pkg::POS_W-1:0]  i_position,
    output ple_pkg::t_ctl              o_ctl,
    output logic [$clog2(DEPTH)-1:0]   o_index,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    import ple_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [PW-1:0] w_pos;
    logic [PW-1:0] w_cnt;

    assign w_pos   = PW'(i_position);
    assign w_cnt   = PW'(r_count);
    assign o_index = IW'(i_position);

    always_comb begin
        n_count      = r_count;
        o_ctl.act    = ACT_NONE;
        o_ctl.take   = 1'b0;
        o_ctl.status = ST_OK;
        unique case (t_kind'(i_kind))
            KIND_INSERT: begin
                if (w_pos > w_cnt) begin
                    o_ctl.status = ST_RANGE;
                end else if (r_count == CW'(DEPTH)) begin
                    o_ctl.status = ST_FULL;
                end else begin
                    o_ctl.act = ACT_INSERT;
                    n_count   = r_count + 1'b1;
                end
            end
            KIND_DELETE: begin
                if (w_pos >= w_cnt) begin
                    o_ctl.status = ST_RANGE;
                end else begin
                    o_ctl.act  = ACT_DELETE;
                    o_ctl.take = 1'b1;
                    n_count    = r_count - 1'b1;
                end
            end
            KIND_REPLACE: begin
                if (w_pos >= w_cnt) begin
                    o_ctl.status = ST_RANGE;
                end else begin
                    o_ctl.act = ACT_WRITE;
                end
            end
            KIND_READ: begin
                if (w_pos >= w_cnt) begin
                    o_ctl.status = ST_RANGE;
                end else begin
                    o_ctl.take = 1'b1;
                end
            end
            KIND_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
        if (!i_accept) begin
            n_count   = r_count;
            o_ctl.act = ACT_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_count = r_count;

endmodule
